>>> sv/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
package sfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] HDR_LEN = 8'd4;

	localparam logic [WORD_W-1:0] HEADER_RST  = 32'h4353_4144;
	localparam logic [WORD_W-1:0] TRAILER_RST = 32'hFEFC_FEFC;
	localparam logic [BYTE_W-1:0] MAXLEN_RST  = 8'd80;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd2;

	localparam logic END_TRAILER = 1'b0;
	localparam logic END_LIMIT   = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] position;
		logic              frame_end;
		logic              end_cause;
	} result_t;

endpackage

>>> sv/sfd_sync.sv
// Header hunt, byte window, frame count and end detection.
module sfd_sync (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [sfd_pkg::BYTE_W-1:0]            rx_byte,
	input  logic [sfd_pkg::WORD_W-1:0]            header_word,
	input  logic [sfd_pkg::WORD_W-1:0]            trailer_word,
	input  logic [sfd_pkg::BYTE_W-1:0]            max_frame_len,
	output sfd_pkg::result_t                      res,
	output logic                                  res_valid
);

	logic [sfd_pkg::WORD_W-1:0] last_four_q;
	logic [sfd_pkg::BYTE_W-1:0] byte_count_q;
	logic [sfd_pkg::WORD_W-1:0] window_nxt;
	logic [sfd_pkg::BYTE_W-1:0] cnt_inc;
	logic [sfd_pkg::BYTE_W-1:0] count_nxt;
	logic                       in_header;
	logic                       trail_hit;
	logic                       limit_hit;

	assign window_nxt = {last_four_q[sfd_pkg::WORD_W-sfd_pkg::BYTE_W-1:0], rx_byte};
	assign cnt_inc    = byte_count_q + 8'd1;
	assign in_header  = (cnt_inc <= sfd_pkg::HDR_LEN);
	assign trail_hit  = (window_nxt == trailer_word);
	assign limit_hit  = (cnt_inc >= max_frame_len);

	always_comb begin
		res_valid     = !in_header;
		res.data_byte = rx_byte;
		res.position  = byte_count_q;
		res.frame_end = 1'b0;
		res.end_cause = sfd_pkg::END_TRAILER;
		count_nxt     = cnt_inc;
		if (in_header) begin
			// slide the hunt window by one byte on a header miss
			if (cnt_inc == sfd_pkg::HDR_LEN && window_nxt != header_word) begin
				count_nxt = sfd_pkg::HDR_LEN - 8'd1;
			end
		end else if (trail_hit || limit_hit) begin
			res.frame_end = 1'b1;
			res.end_cause = trail_hit ? sfd_pkg::END_TRAILER : sfd_pkg::END_LIMIT;
			count_nxt     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_four_q  <= '0;
			byte_count_q <= '0;
		end else if (accept) begin
			last_four_q  <= window_nxt;
			byte_count_q <= count_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_end_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && res.frame_end) |=> (byte_count_q == '0))
		else $error("count not cleared after frame end");

	a_miss_slides: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_count_q == 8'd3 && window_nxt != header_word)
		|=> (byte_count_q == 8'd3))
		else $error("header miss did not hold count at three");

	a_result_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (byte_count_q >= sfd_pkg::HDR_LEN))
		else $error("result emitted for a header byte");

	a_cause_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.end_cause == sfd_pkg::END_LIMIT) |-> res.frame_end)
		else $error("end cause set without frame end");
`endif

endmodule

>>> sv/sfd_out_reg.sv
// Output register holding one result beat toward the master side.
module sfd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             load_valid,
	input  sfd_pkg::result_t res,
	output logic             ready,
	output logic             valid,
	output sfd_pkg::result_t data,
	input  logic             take
);

	logic             valid_q;
	sfd_pkg::result_t data_q;

	// free when empty or when the held beat leaves this cycle
	assign ready = !valid_q || take;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			data_q <= res;
		end
	end

endmodule

>>> sv/serial_frame_deframer.sv
// Top level: config registers, frame sync core and output register.
// A result beat appears on m_tvalid in the cycle after its byte is accepted.
// One byte per cycle unless m_tready stalls; the output frees in the cycle it drains.
// Header bytes and mismatched hunt bytes produce no output beat.
// Reset clears the byte window, frame count and output valid, and loads
// the default header, trailer and length limit.
module serial_frame_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfd_pkg::WORD_W-1:0]        cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // [7:0] data_byte, [15:8] position
	output logic                              m_tlast,   // frame_end
	output logic                              m_tuser    // end_cause
);

	logic [sfd_pkg::WORD_W-1:0] header_q;
	logic [sfd_pkg::WORD_W-1:0] trailer_q;
	logic [sfd_pkg::BYTE_W-1:0] maxlen_q;
	logic                       accept;
	logic                       res_valid;
	sfd_pkg::result_t           res;
	sfd_pkg::result_t           out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= sfd_pkg::HEADER_RST;
			trailer_q <= sfd_pkg::TRAILER_RST;
			maxlen_q  <= sfd_pkg::MAXLEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sfd_pkg::CFG_HEADER:  header_q  <= cfg_data;
				sfd_pkg::CFG_TRAILER: trailer_q <= cfg_data;
				sfd_pkg::CFG_MAXLEN:  maxlen_q  <= cfg_data[sfd_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	sfd_sync u_sync (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (s_tdata),
		.header_word  (header_q),
		.trailer_word (trailer_q),
		.max_frame_len(maxlen_q),
		.res          (res),
		.res_valid    (res_valid)
	);

	sfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_valid(res_valid),
		.res       (res),
		.ready     (s_tready),
		.valid     (m_tvalid),
		.data      (out_data),
		.take      (m_tready)
	);

	assign m_tdata = {out_data.position, out_data.data_byte};
	assign m_tlast = out_data.frame_end;
	assign m_tuser = out_data.end_cause;

endmodule
